FILE: rtl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants for the minimum spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmst_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MaxEdgesDef    = 2048;
  localparam int unsigned WeightBitsDef  = 16;

  localparam int unsigned VidW   = 6;   // endpoint field width
  localparam int unsigned NvW    = 7;   // vertex count register width
  localparam int unsigned TotalW = 22;  // running total width
  localparam int unsigned OcW    = 2;

  typedef enum logic [OcW-1:0] {
    OC_COMPLETE     = 2'd0,
    OC_DISCONNECTED = 2'd1,
    OC_DROPPED      = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_CHECK,
    ST_FRD,
    ST_FWT,
    ST_CRD,
    ST_CWT,
    ST_RKA,
    ST_RKB,
    ST_RKC,
    ST_PUSH,
    ST_NEXT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/kruskal_min_spanning_tree.sv
// ----------------------------------------------------------------------------
// kruskal_min_spanning_tree
// Minimum spanning tree over a loaded edge list, union-find in block RAM.
// ----------------------------------------------------------------------------
// Loading: one edge beat per cycle, no results until the final edge.
// Run: per edge taken in sorted order, one full scan of the edge store
//   through the single read port of the edge RAM plus a check and a step
//   state, then find/compress walks with a read and a wait state per vertex
//   visited, and RKA, RKB, RKC and PUSH for a union with its result hand-off.
// Whole run: an init pass over all MAX_VERTICES parent/rank entries, then
//   the scans and walks; the input stays stalled until the last beat is loaded.
// Reset: asynchronous, clears control state; RAM contents stay undefined and
//   the parent/rank RAMs are initialised at the start of every run.
`default_nettype none

module kruskal_min_spanning_tree #(
  parameter int unsigned MAX_VERTICES = kmst_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = kmst_pkg::MaxEdgesDef,
  parameter int unsigned WEIGHT_BITS  = kmst_pkg::WeightBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [kmst_pkg::NvW-1:0]    cfg_wdata_i,
  // edge input
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [kmst_pkg::VidW-1:0]   end_a_i,
  input  wire logic [kmst_pkg::VidW-1:0]   end_b_i,
  input  wire logic [WEIGHT_BITS-1:0]      edge_cost_i,
  input  wire logic                        final_edge_i,
  // tree output
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [kmst_pkg::VidW-1:0]        tree_a_o,
  output logic [kmst_pkg::VidW-1:0]        tree_b_o,
  output logic [WEIGHT_BITS-1:0]           tree_cost_o,
  output logic [kmst_pkg::TotalW-1:0]      running_total_o,
  output logic                             edge_present_o,
  output logic                             run_end_o,
  output logic [kmst_pkg::OcW-1:0]         outcome_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EW  = WEIGHT_BITS + 2 * kmst_pkg::VidW;
  localparam int unsigned KW  = WEIGHT_BITS + CW;
  localparam int unsigned NV  = kmst_pkg::NvW;
  localparam int unsigned VID = kmst_pkg::VidW;
  localparam int unsigned TW  = kmst_pkg::TotalW;

  kmst_pkg::state_e state_q, state_d;

  // configuration and effective vertex count
  logic [NV-1:0] nv_q, n_eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= NV'(64);
    end else if (cfg_we_i) begin
      nv_q <= cfg_wdata_i;
    end
  end
  always_comb begin
    if (nv_q == '0) begin
      n_eff = NV'(1);
    end else if (nv_q > NV'(MAX_VERTICES)) begin
      n_eff = NV'(MAX_VERTICES);
    end else begin
      n_eff = nv_q;
    end
  end

  // ---------------------------------------------------------------- edge RAM
  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic          edge_we;
  logic [AW-1:0] edge_waddr, edge_raddr;
  logic [EW-1:0] edge_wdata, edge_rdata_q;

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata_q <= edge_mem[edge_raddr];
  end

  // ------------------------------------------------------ parent / rank RAMs
  logic [VW-1:0] par_mem [MAX_VERTICES];
  logic [2:0]    rank_mem [MAX_VERTICES];
  logic          par_we, rank_we;
  logic [VW-1:0] par_waddr, par_wdata, par_raddr, par_rdata_q;
  logic [VW-1:0] rank_waddr, rank_raddr;
  logic [2:0]    rank_wdata, rank_rdata_q;

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata_q <= par_mem[par_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata_q <= rank_mem[rank_raddr];
  end

  // ---------------------------------------------------------- control state
  logic [CW-1:0]  count_q;
  logic           dropped_q;
  logic [TW-1:0]  total_q;
  logic [NV-1:0]  found_q;
  logic [VW-1:0]  init_q;

  // scan: lexicographic (weight, index) selection gives a stable sort order
  logic [CW-1:0]  scan_i_q;
  logic           rd_pend_q;
  logic [CW-1:0]  rd_idx_q;
  logic           has_last_q, has_best_q;
  logic [KW-1:0]  last_key_q, best_key_q;
  logic [VID-1:0] best_a_q, best_b_q;
  logic [WEIGHT_BITS-1:0] best_w_q;

  // union-find walk
  logic           side_q;
  logic [VW-1:0]  cur_q, root_q, rx_q, ry_q;
  logic [2:0]     rkx_q;

  // pending result, held back until we know whether it is the last one
  logic           pend_v_q;
  logic [VID-1:0] pend_a_q, pend_b_q;
  logic [WEIGHT_BITS-1:0] pend_w_q;
  logic [TW-1:0]  pend_tot_q;

  // output register
  logic           out_valid_q;
  logic           slot_free, out_load;

  logic           in_accept, ep_ok, store_full, scan_done;
  logic [KW-1:0]  rd_key;
  logic           cand;
  logic           best_bad;
  logic [VW-1:0]  best_av, best_bv;
  logic [TW-1:0]  new_total;
  kmst_pkg::outcome_e oc;

  assign in_stall_o = (state_q != kmst_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ep_ok      = ({1'b0, end_a_i} < n_eff) && ({1'b0, end_b_i} < n_eff);
  assign store_full = (count_q == CW'(MAX_EDGES));

  assign edge_we    = in_accept && ep_ok && !store_full;
  assign edge_waddr = count_q[AW-1:0];
  assign edge_wdata = {edge_cost_i, end_b_i, end_a_i};
  assign edge_raddr = scan_i_q[AW-1:0];

  assign rd_key = {edge_rdata_q[EW-1 -: WEIGHT_BITS], rd_idx_q};
  assign cand   = rd_pend_q && (!has_last_q || (rd_key > last_key_q))
                            && (!has_best_q || (rd_key < best_key_q));
  assign scan_done = (scan_i_q == count_q) && !rd_pend_q;

  assign best_bad  = ({1'b0, best_a_q} >= n_eff) || ({1'b0, best_b_q} >= n_eff);
  assign best_av   = best_a_q[VW-1:0];
  assign best_bv   = best_b_q[VW-1:0];
  assign new_total = total_q + TW'(best_w_q);

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (dropped_q) begin
      oc = kmst_pkg::OC_DROPPED;
    end else if ((found_q + NV'(1)) >= n_eff) begin
      oc = kmst_pkg::OC_COMPLETE;
    end else begin
      oc = kmst_pkg::OC_DISCONNECTED;
    end
  end

  // ------------------------------------------------------ next state / RAM ctl
  always_comb begin
    state_d    = state_q;
    par_we     = 1'b0;
    par_waddr  = cur_q;
    par_wdata  = root_q;
    par_raddr  = cur_q;
    rank_we    = 1'b0;
    rank_waddr = init_q;
    rank_wdata = '0;
    rank_raddr = rx_q;
    out_load   = 1'b0;
    unique case (state_q)
      kmst_pkg::ST_IDLE: begin
        if (in_accept && final_edge_i) begin
          state_d = kmst_pkg::ST_INIT;
        end
      end
      kmst_pkg::ST_INIT: begin
        par_we     = 1'b1;
        par_waddr  = init_q;
        par_wdata  = init_q;
        rank_we    = 1'b1;
        rank_waddr = init_q;
        rank_wdata = '0;
        if (init_q == VW'(MAX_VERTICES - 1)) begin
          state_d = (n_eff == NV'(1)) ? kmst_pkg::ST_FINISH : kmst_pkg::ST_SCAN;
        end
      end
      kmst_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = has_best_q ? kmst_pkg::ST_CHECK : kmst_pkg::ST_FINISH;
        end
      end
      kmst_pkg::ST_CHECK: begin
        state_d = best_bad ? kmst_pkg::ST_NEXT : kmst_pkg::ST_FRD;
      end
      kmst_pkg::ST_FRD: begin
        state_d = kmst_pkg::ST_FWT;
      end
      kmst_pkg::ST_FWT: begin
        state_d = (par_rdata_q == cur_q) ? kmst_pkg::ST_CRD : kmst_pkg::ST_FRD;
      end
      kmst_pkg::ST_CRD: begin
        state_d = kmst_pkg::ST_CWT;
      end
      kmst_pkg::ST_CWT: begin
        if (par_rdata_q != root_q) begin
          par_we  = 1'b1;
          state_d = kmst_pkg::ST_CRD;
        end else if (!side_q) begin
          state_d = kmst_pkg::ST_FRD;
        end else begin
          state_d = (rx_q != root_q) ? kmst_pkg::ST_RKA : kmst_pkg::ST_NEXT;
        end
      end
      kmst_pkg::ST_RKA: begin
        rank_raddr = rx_q;
        state_d    = kmst_pkg::ST_RKB;
      end
      kmst_pkg::ST_RKB: begin
        rank_raddr = ry_q;
        state_d    = kmst_pkg::ST_RKC;
      end
      kmst_pkg::ST_RKC: begin
        // union by rank: lower rank goes under higher, ties grow the first
        par_we = 1'b1;
        priority if (rkx_q < rank_rdata_q) begin
          par_waddr = rx_q;
          par_wdata = ry_q;
        end else if (rkx_q > rank_rdata_q) begin
          par_waddr = ry_q;
          par_wdata = rx_q;
        end else begin
          par_waddr  = ry_q;
          par_wdata  = rx_q;
          rank_we    = 1'b1;
          rank_waddr = rx_q;
          rank_wdata = rkx_q + 3'd1;
        end
        state_d = kmst_pkg::ST_PUSH;
      end
      kmst_pkg::ST_PUSH: begin
        if (!pend_v_q || slot_free) begin
          out_load = pend_v_q;
          state_d  = ((found_q + NV'(1)) >= n_eff) ? kmst_pkg::ST_FINISH
                                                   : kmst_pkg::ST_NEXT;
        end
      end
      kmst_pkg::ST_NEXT: begin
        state_d = kmst_pkg::ST_SCAN;
      end
      kmst_pkg::ST_FINISH: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = kmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kmst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ----------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      dropped_q  <= 1'b0;
      total_q    <= '0;
      found_q    <= '0;
      init_q     <= '0;
      scan_i_q   <= '0;
      rd_pend_q  <= 1'b0;
      has_last_q <= 1'b0;
      has_best_q <= 1'b0;
      side_q     <= 1'b0;
      pend_v_q   <= 1'b0;
    end else begin
      unique case (state_q)
        kmst_pkg::ST_IDLE: begin
          init_q     <= '0;
          scan_i_q   <= '0;
          rd_pend_q  <= 1'b0;
          has_last_q <= 1'b0;
          has_best_q <= 1'b0;
          if (in_accept) begin
            if (edge_we) begin
              count_q <= count_q + CW'(1);
            end else begin
              dropped_q <= 1'b1;
            end
          end
        end
        kmst_pkg::ST_INIT: begin
          init_q <= init_q + VW'(1);
        end
        kmst_pkg::ST_SCAN: begin
          rd_pend_q <= (scan_i_q != count_q);
          if (scan_i_q != count_q) begin
            scan_i_q <= scan_i_q + CW'(1);
          end
          if (cand) begin
            has_best_q <= 1'b1;
          end
        end
        kmst_pkg::ST_CHECK: begin
          side_q <= 1'b0;
          if (best_bad) begin
            dropped_q <= 1'b1;
          end
        end
        kmst_pkg::ST_CWT: begin
          if ((par_rdata_q == root_q) && !side_q) begin
            side_q <= 1'b1;
          end
        end
        kmst_pkg::ST_RKC: begin
          total_q <= new_total;
          found_q <= found_q + NV'(1);
        end
        kmst_pkg::ST_PUSH: begin
          if (!pend_v_q || slot_free) begin
            pend_v_q <= 1'b1;
          end
        end
        kmst_pkg::ST_NEXT: begin
          has_last_q <= 1'b1;
          has_best_q <= 1'b0;
          scan_i_q   <= '0;
          rd_pend_q  <= 1'b0;
        end
        kmst_pkg::ST_FINISH: begin
          if (slot_free) begin
            count_q   <= '0;
            dropped_q <= 1'b0;
            total_q   <= '0;
            found_q   <= '0;
            pend_v_q  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ----------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (state_q == kmst_pkg::ST_SCAN && cand) begin
      best_key_q <= rd_key;
      best_a_q   <= edge_rdata_q[VID-1:0];
      best_b_q   <= edge_rdata_q[2*VID-1:VID];
      best_w_q   <= edge_rdata_q[EW-1 -: WEIGHT_BITS];
    end
    if (state_q == kmst_pkg::ST_SCAN) begin
      rd_idx_q <= scan_i_q;
    end
    if (state_q == kmst_pkg::ST_NEXT) begin
      last_key_q <= best_key_q;
    end
    unique case (state_q)
      kmst_pkg::ST_CHECK: begin
        cur_q <= best_av;
      end
      kmst_pkg::ST_FWT: begin
        if (par_rdata_q == cur_q) begin
          root_q <= cur_q;
          cur_q  <= side_q ? best_bv : best_av;
        end else begin
          cur_q <= par_rdata_q;
        end
      end
      kmst_pkg::ST_CWT: begin
        if (par_rdata_q != root_q) begin
          cur_q <= par_rdata_q;
        end else if (!side_q) begin
          rx_q  <= root_q;
          cur_q <= best_bv;
        end else begin
          ry_q <= root_q;
        end
      end
      kmst_pkg::ST_RKB: begin
        rkx_q <= rank_rdata_q;
      end
      kmst_pkg::ST_PUSH: begin
        if (!pend_v_q || slot_free) begin
          pend_a_q   <= best_a_q;
          pend_b_q   <= best_b_q;
          pend_w_q   <= best_w_q;
          pend_tot_q <= total_q;
        end
      end
      default: begin
      end
    endcase
  end

  // ----------------------------------------------------------- output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (pend_v_q) begin
        tree_a_o        <= pend_a_q;
        tree_b_o        <= pend_b_q;
        tree_cost_o     <= pend_w_q;
        running_total_o <= pend_tot_q;
        edge_present_o  <= 1'b1;
      end else begin
        // empty tree: status-only beat
        tree_a_o        <= '0;
        tree_b_o        <= '0;
        tree_cost_o     <= '0;
        running_total_o <= '0;
        edge_present_o  <= 1'b0;
      end
      run_end_o <= (state_q == kmst_pkg::ST_FINISH);
      outcome_o <= (state_q == kmst_pkg::ST_FINISH) ? oc : kmst_pkg::OC_COMPLETE;
    end
  end

  assign out_valid_o = out_valid_q;

  // ----------------------------------------------------------- assertions
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("output beat overwritten while stalled");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q < n_eff || state_q != kmst_pkg::ST_IDLE)
    else $error("tree edge count exceeds vertex count");

  a_no_uf_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmst_pkg::ST_IDLE) |-> !par_we && !rank_we)
    else $error("union-find RAM written while loading");

  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == kmst_pkg::ST_FINISH) |=> state_q == kmst_pkg::ST_IDLE)
    else $error("last beat did not end the run");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum spanning tree block: edge beats are
// offered from a queue, a local Kruskal predictor builds the expected tree
// edges per graph and a monitor compares every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam int MaxV     = 64;
  localparam int MaxE     = 2048;
  localparam int Watchdog = 200000;
  localparam int Tail     = 200;

  typedef struct packed {
    logic [5:0]  a;
    logic [5:0]  b;
    logic [15:0] w;
    logic        fin;
  } edge_beat_t;

  typedef struct packed {
    logic [5:0]  a;
    logic [5:0]  b;
    logic [15:0] w;
    logic [21:0] tot;
    logic        present;
    logic        last;
    kmst_pkg::outcome_e oc;
  } tree_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [5:0] end_a_i = '0, end_b_i = '0;
  logic [15:0] edge_cost_i = '0;
  logic final_edge_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [5:0] tree_a_o, tree_b_o;
  logic [15:0] tree_cost_o;
  logic [21:0] running_total_o;
  logic edge_present_o, run_end_o;
  logic [1:0] outcome_o;

  always #6 clk_i = ~clk_i;

  kruskal_min_spanning_tree dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .end_a_i, .end_b_i, .edge_cost_i, .final_edge_i,
    .out_valid_o, .out_stall_i, .tree_a_o, .tree_b_o, .tree_cost_o,
    .running_total_o, .edge_present_o, .run_end_o, .outcome_o
  );

  // predictor state
  edge_beat_t edge_mem[$];
  logic       drop_seen;
  logic [6:0] nv_reg;
  tree_beat_t tree_expect_q[$];
  edge_beat_t pending_q[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;      // no idling in the final stretch
  bit  hold_req = 1'b0;  // ask the monitor for one long hold-off

  function automatic int used_vertices();
    if (nv_reg == 0) return 1;
    if (nv_reg > MaxV) return MaxV;
    return int'(nv_reg);
  endfunction

  // union-find on the predictor's own tables
  function automatic int find_root(ref logic [5:0] par[MaxV], input int v);
    int r;
    int nx;
    r = v;
    while (par[r] != r) r = par[r];
    while (par[v] != r) begin
      nx = par[v];
      par[v] = 6'(r);
      v = nx;
    end
    return r;
  endfunction

  // a beat as the block takes it: store or drop, then solve on the final edge
  task automatic predict_tree(input edge_beat_t e);
    int n;
    int order[$];
    int j;
    int x, y;
    int found;
    logic [5:0] par[MaxV];
    logic [2:0] rnk[MaxV];
    logic [21:0] total;
    tree_beat_t t;
    kmst_pkg::outcome_e oc;
    n = used_vertices();
    if (e.a >= n || e.b >= n || edge_mem.size() >= MaxE) drop_seen = 1'b1;
    else edge_mem.insert(edge_mem.size(), e);
    if (!e.fin) return;
    // stable insertion sort by weight
    for (int i = 0; i < edge_mem.size(); i++) begin
      j = order.size();
      while (j > 0 && edge_mem[order[j-1]].w > edge_mem[i].w) j--;
      order.insert(j, i);
    end
    for (int i = 0; i < MaxV; i++) begin
      par[i] = 6'(i);
      rnk[i] = '0;
    end
    total = '0;
    found = 0;
    for (int i = 0; i < order.size() && found + 1 < n; i++) begin
      e = edge_mem[order[i]];
      if (e.a >= n || e.b >= n) begin
        drop_seen = 1'b1;
        continue;
      end
      x = find_root(par, e.a);
      y = find_root(par, e.b);
      if (x != y) begin
        total = total + 22'(e.w);
        found++;
        if (rnk[x] < rnk[y]) par[x] = 6'(y);
        else if (rnk[x] > rnk[y]) par[y] = 6'(x);
        else begin
          par[y] = 6'(x);
          rnk[x] = rnk[x] + 3'd1;
        end
        t = '{a: e.a, b: e.b, w: e.w, tot: total, present: 1'b1, last: 1'b0,
              oc: kmst_pkg::OC_COMPLETE};
        tree_expect_q.insert(tree_expect_q.size(), t);
      end
    end
    if (drop_seen) oc = kmst_pkg::OC_DROPPED;
    else if (found + 1 >= n) oc = kmst_pkg::OC_COMPLETE;
    else oc = kmst_pkg::OC_DISCONNECTED;
    if (found == 0) begin
      t = '{a: '0, b: '0, w: '0, tot: '0, present: 1'b0, last: 1'b1, oc: oc};
      tree_expect_q.insert(tree_expect_q.size(), t);
    end else begin
      tree_expect_q[tree_expect_q.size()-1].last = 1'b1;
      tree_expect_q[tree_expect_q.size()-1].oc = oc;
    end
    edge_mem.delete();
    drop_seen = 1'b0;
  endtask

  // driver: one beat offered from the pending queue, random gap bursts
  int gap_left = 0;

  // acceptance and driving in one process on the falling edge, using a flag
  // captured at the rising edge
  bit in_took;
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) predict_tree(pending_q[0]);
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) void'(pending_q.pop_front());
      if (gap_left > 0 && !(in_valid_i && !in_took)) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (in_valid_i && !in_took) begin
        // stalled beat stays put
      end else begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          edge_beat_t nb;
          nb = pending_q[0];
          in_valid_i <= 1'b1;
          end_a_i <= nb.a;
          end_b_i <= nb.b;
          edge_cost_i <= nb.w;
          final_edge_i <= nb.fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  int stall_left = 0;
  always @(posedge clk_i) begin
    tree_beat_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tree_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tree beat a=%0d b=%0d w=%0d", tree_a_o, tree_b_o,
                   tree_cost_o);
      end else begin
        exp_b = tree_expect_q.pop_front();
        if (tree_a_o !== exp_b.a || tree_b_o !== exp_b.b ||
            tree_cost_o !== exp_b.w || running_total_o !== exp_b.tot ||
            edge_present_o !== exp_b.present || run_end_o !== exp_b.last ||
            outcome_o !== exp_b.oc) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tree beat mismatch: exp %0d %0d %0d %0d %b %b %0d",
                      " got %0d %0d %0d %0d %b %b %0d"},
                     exp_b.a, exp_b.b, exp_b.w, exp_b.tot, exp_b.present,
                     exp_b.last, exp_b.oc, tree_a_o, tree_b_o, tree_cost_o,
                     running_total_o, edge_present_o, run_end_o, outcome_o);
        end
      end
    end
  end

  // receiver stall: random bursts, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      out_stall_i <= 1'b1;
      stall_left = 300;
      hold_req = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic add_edge(input int a, input int b, input int w, input bit fin);
    edge_beat_t e;
    e = '{a: a[5:0], b: b[5:0], w: w[15:0], fin: fin};
    pending_q.insert(pending_q.size(), e);
  endtask

  // wait for the graph in flight to drain, then write the vertex count
  task automatic set_vertices(input int nv);
    wait (pending_q.size() == 0 && !in_valid_i && tree_expect_q.size() == 0);
    repeat (Tail) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= nv[6:0];
    nv_reg = nv[6:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a graph of k random edges over vertices below lim, mostly in range
  task automatic random_graph(input int k, input int lim);
    for (int i = 0; i < k; i++)
      add_edge($urandom_range(0, lim - 1), $urandom_range(0, lim - 1),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 15),
               i == k - 1);
  endtask

  initial begin
    int nv;
    nv_reg = 7'd64;
    drop_seen = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset count 64, extremes of every field
    add_edge(63, 0, 65535, 0);
    add_edge(0, 63, 0, 0);
    add_edge(5, 5, 7, 0);          // self loop
    add_edge(42, 21, 7, 0);        // tie with the self loop
    add_edge(21, 42, 7, 1);        // parallel edge, never taken
    set_vertices(1);                // single vertex: empty tree, complete
    add_edge(0, 0, 3, 1);
    set_vertices(0);                // zero read as one; endpoint 1 is dropped
    add_edge(1, 0, 9, 1);
    set_vertices(4);                // disconnected graph
    add_edge(0, 1, 4, 0);
    add_edge(2, 3, 4, 1);
    add_edge(0, 1, 2, 0);           // complete graph
    add_edge(1, 2, 1, 0);
    add_edge(2, 3, 1, 0);
    add_edge(3, 0, 1, 1);
    set_vertices(127);              // above the maximum, read as 64
    add_edge(40, 50, 100, 0);
    set_vertices(2);                // stored edge re-checked at run time
    add_edge(0, 1, 5, 1);
    set_vertices(64);

    // random graphs with varying vertex counts
    for (int g = 0; g < 30; g++) begin
      if (g % 6 == 5) begin
        nv = (g % 12 == 5) ? 64 : $urandom_range(1, 16);
        set_vertices(nv);
      end
      if (g == 10) begin
        hold_req = 1'b1;
        random_graph(40, used_vertices());
      end else if (g >= 24) begin
        calm = 1'b1;
        random_graph($urandom_range(5, 20), used_vertices());
      end else begin
        random_graph($urandom_range(3, 24), used_vertices() + (g % 4 == 0 ? 2 : 0));
      end
    end
    wait (pending_q.size() == 0 && !in_valid_i && tree_expect_q.size() == 0);
    repeat (Tail) @(posedge clk_i);
    if (mismatches == 0 && tree_expect_q.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
